/* rtl/rbd_pkg.sv */
// shared constants, types and lane arithmetic for the rgba box downsampler
`default_nettype none

package rbd_pkg;

	localparam int unsigned CHAN_W = 8;
	localparam int unsigned LANES = 4;
	localparam int unsigned LANE_W = 9;
	localparam int unsigned PIX_W = LANES * CHAN_W;
	localparam int unsigned SUM_W = LANES * LANE_W;
	localparam int unsigned DIM_W = 14;
	localparam int unsigned CNT_W = 13;
	localparam int unsigned PAIR_W = CNT_W - 1;
	localparam int unsigned MAX_WIDTH_DEFAULT = 8192;
	localparam int unsigned MAX_HEIGHT = 8192;
	localparam int unsigned RESET_DIM = 4096;
	localparam int unsigned CFG_INDEX_W = 1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SOURCE_WIDTH  = 1'b0,
		REG_SOURCE_HEIGHT = 1'b1
	} cfg_reg_t;

	// per-pixel position flags worked out when the pixel is taken
	typedef struct packed {
		logic              col_odd;
		logic              pair_ok;
		logic              row_odd;
		logic              out_ok;
		logic              last;
		logic [PAIR_W-1:0] pair;
	} rbd_ctrl_t;

	// line store access strobes
	typedef struct packed {
		logic we;
		logic re;
	} rbd_store_req_t;

	// four 8-bit channels into four 9-bit lanes
	function automatic logic [SUM_W-1:0] widen(input logic [PIX_W-1:0] pix);
		logic [SUM_W-1:0] r;
		r = '0;
		for (int k = 0; k < LANES; k++) begin
			r[k*LANE_W +: LANE_W] = {1'b0, pix[k*CHAN_W +: CHAN_W]};
		end
		return r;
	endfunction

	// lane-wise add, each lane kept to 9 bits
	function automatic logic [SUM_W-1:0] add_lanes(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W-1:0] r;
		r = '0;
		for (int k = 0; k < LANES; k++) begin
			r[k*LANE_W +: LANE_W] = a[k*LANE_W +: LANE_W] + b[k*LANE_W +: LANE_W];
		end
		return r;
	endfunction

	// sum of upper and lower pair sums, divided by four
	function automatic logic [PIX_W-1:0] block_avg(input logic [SUM_W-1:0] up,
		input logic [SUM_W-1:0] lo);
		logic [PIX_W-1:0] r;
		logic [LANE_W:0]  s;
		r = '0;
		for (int k = 0; k < LANES; k++) begin
			s = {1'b0, up[k*LANE_W +: LANE_W]} + {1'b0, lo[k*LANE_W +: LANE_W]};
			r[k*CHAN_W +: CHAN_W] = s[LANE_W:2];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/rgba_box_downsample_by_two.sv */
// top level of the 2x2 box filter rgba downsampler
`default_nettype none

// Halves an RGBA picture that arrives one pixel per transfer in raster order.
// Each output channel is the truncated mean of a 2x2 source block; an odd
// source width drops the last column and an odd height drops the last row, so
// a picture one pixel wide or high gives nothing. Output pixels leave in
// raster order of the halved picture and tlast marks the final one. The block
// takes one pixel every clock cycle while the output side keeps up. The result
// of a block goes from the transfer of its bottom-right pixel through the input
// register, where the line store read is issued, and the read stage, whose
// registered read (MAX_WIDTH/2 words of four 9-bit pair sums) feeds the final
// add ahead of the output register. While a result waits at the output the read
// stage can hold one more; input stops only once a third block is completed in
// the input register. No clearing pass is needed after reset. Writing either
// size register restarts the frame; the user must write sizes only while the
// block is idle, which the block itself does not enforce. Width is clamped to
// 1..MAX_WIDTH, height to 1..8192.
module rgba_box_downsample_by_two #(
	parameter int unsigned MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// pixel input
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [rbd_pkg::PIX_W-1:0]         s_tdata,   // red_in, green_in, blue_in, alpha_in
	// halved pixel output
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [rbd_pkg::PIX_W-1:0]              m_tdata,   // red_out, green_out, blue_out, alpha_out
	output logic                                   m_tlast,   // frame_last
	// size register writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rbd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [rbd_pkg::DIM_W-1:0]         cfg_data
);

	localparam int unsigned DEPTH = MAX_WIDTH / 2;
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [16:0] MAXW = 17'(MAX_WIDTH);
	localparam logic [rbd_pkg::DIM_W-1:0] RESET_W =
		rbd_pkg::DIM_W'((MAX_WIDTH < rbd_pkg::RESET_DIM) ? MAX_WIDTH : rbd_pkg::RESET_DIM);
	localparam logic [rbd_pkg::DIM_W-1:0] RESET_H = rbd_pkg::DIM_W'(rbd_pkg::RESET_DIM);
	localparam logic [rbd_pkg::DIM_W-1:0] MAXH = rbd_pkg::DIM_W'(rbd_pkg::MAX_HEIGHT);

	// effective (clamped) picture size
	logic [rbd_pkg::DIM_W-1:0] w_q, h_q, w_new, h_new;
	// position of the next source pixel
	logic [rbd_pkg::CNT_W-1:0] col_q, row_q;

	logic s_xfer, cfg_xfer;

	// input register stage
	logic                       valid_s1;
	logic [rbd_pkg::PIX_W-1:0]  pix_s1;
	rbd_pkg::rbd_ctrl_t         ctrl_s1;
	rbd_pkg::rbd_ctrl_t         ctrl_in;

	// left pixel of the current horizontal pair
	logic [rbd_pkg::SUM_W-1:0]  pair_sum_q;
	logic [rbd_pkg::SUM_W-1:0]  hsum;

	// stage waiting on the line store read
	logic                       valid_s2;
	logic [rbd_pkg::SUM_W-1:0]  hsum_s2;
	logic                       last_s2;
	logic [rbd_pkg::SUM_W-1:0]  up_s2;

	logic out_free, s2_free, s1_out, s1_wr, s1_adv;
	rbd_pkg::rbd_store_req_t store_req;
	logic [AW-1:0] store_addr;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;
	assign s_xfer    = s_tvalid & s_tready;

	// clamp written sizes: zero counts as one
	always_comb begin
		if (cfg_data == '0) begin
			w_new = rbd_pkg::DIM_W'(1);
		end else if ({3'b000, cfg_data} > MAXW) begin
			w_new = rbd_pkg::DIM_W'(MAXW);
		end else begin
			w_new = cfg_data;
		end
		if (cfg_data == '0) begin
			h_new = rbd_pkg::DIM_W'(1);
		end else if (cfg_data > MAXH) begin
			h_new = MAXH;
		end else begin
			h_new = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= RESET_W;
			h_q <= RESET_H;
		end else if (cfg_xfer) begin
			case (rbd_pkg::cfg_reg_t'(cfg_index))
				rbd_pkg::REG_SOURCE_WIDTH:  w_q <= w_new;
				rbd_pkg::REG_SOURCE_HEIGHT: h_q <= h_new;
				default: ;
			endcase
		end
	end

	// raster position; a size write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_xfer) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_xfer) begin
			if ({1'b0, col_q} + rbd_pkg::DIM_W'(1) >= w_q) begin
				col_q <= '0;
				if ({1'b0, row_q} + rbd_pkg::DIM_W'(1) >= h_q) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + rbd_pkg::CNT_W'(1);
				end
			end else begin
				col_q <= col_q + rbd_pkg::CNT_W'(1);
			end
		end
	end

	// position flags of the incoming pixel
	always_comb begin
		ctrl_in.col_odd = col_q[0];
		ctrl_in.row_odd = row_q[0];
		ctrl_in.pair    = col_q[rbd_pkg::CNT_W-1:1];
		ctrl_in.pair_ok = {1'b0, ctrl_in.pair} < w_q[rbd_pkg::DIM_W-1:1];
		ctrl_in.out_ok  = {1'b0, row_q[rbd_pkg::CNT_W-1:1]} < h_q[rbd_pkg::DIM_W-1:1];
		ctrl_in.last    =
			({1'b0, ctrl_in.pair} + rbd_pkg::CNT_W'(1) == w_q[rbd_pkg::DIM_W-1:1]) &&
			({1'b0, row_q[rbd_pkg::CNT_W-1:1]} + rbd_pkg::CNT_W'(1) ==
			 h_q[rbd_pkg::DIM_W-1:1]);
	end

	// stall chain: each stage moves when the one after it has room
	assign out_free = !m_tvalid || m_tready;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_out   = ctrl_s1.col_odd && ctrl_s1.pair_ok && ctrl_s1.row_odd && ctrl_s1.out_ok;
	assign s1_wr    = ctrl_s1.col_odd && ctrl_s1.pair_ok && !ctrl_s1.row_odd;
	assign s1_adv   = valid_s1 && (!s1_out || s2_free);
	assign s_tready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			pix_s1  <= s_tdata;
			ctrl_s1 <= ctrl_in;
		end
	end

	assign hsum = rbd_pkg::add_lanes(pair_sum_q, rbd_pkg::widen(pix_s1));

	always_ff @(posedge clk) begin
		if (s1_adv && !ctrl_s1.col_odd) begin
			pair_sum_q <= rbd_pkg::widen(pix_s1);
		end
	end

	// upper row writes its pair sums, lower row reads them back
	assign store_req.we = s1_adv && s1_wr;
	assign store_req.re = s1_adv && s1_out;
	assign store_addr   = AW'(ctrl_s1.pair);

	rbd_line_store #(
		.DEPTH (DEPTH)
	) u_line_store (
		.clk   (clk),
		.req   (store_req),
		.waddr (store_addr),
		.wdata (hsum),
		.raddr (store_addr),
		.rdata (up_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (store_req.re) begin
			valid_s2 <= 1'b1;
		end else if (out_free) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (store_req.re) begin
			hsum_s2 <= hsum;
			last_s2 <= ctrl_s1.last;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (valid_s2 && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && out_free) begin
			m_tdata <= rbd_pkg::block_avg(up_s2, hsum_s2);
			m_tlast <= last_s2;
		end
	end

	// line store is never written and read in the same cycle
	a_store_single_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(store_req.we && store_req.re))
		else $error("line store written and read together");

	// column position always lies inside the picture
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, col_q} < w_q))
		else $error("column position beyond width");

	// a waiting read result is not dropped while the output stalls
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && m_tvalid && !m_tready) |=> valid_s2)
		else $error("read stage lost under output stall");

	// an empty input stage always takes a pixel
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input refused with empty input stage");

	// a result only enters the output register from a filled read stage
	a_out_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) && !valid_s2 |=> !m_tvalid)
		else $error("output became valid without a pending result");

endmodule

`default_nettype wire

/* rtl/rbd_line_store.sv */
// line store of horizontal pair sums with registered read
`default_nettype none

module rbd_line_store #(
	parameter int unsigned DEPTH = rbd_pkg::MAX_WIDTH_DEFAULT / 2,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                       clk,
	input  wire rbd_pkg::rbd_store_req_t    req,
	input  wire logic [AW-1:0]              waddr,
	input  wire logic [rbd_pkg::SUM_W-1:0]  wdata,
	input  wire logic [AW-1:0]              raddr,
	output logic [rbd_pkg::SUM_W-1:0]       rdata
);

	logic [rbd_pkg::SUM_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* sim/rbd_halving_check.sv */
// channel monitor, halved pixel predictor and comparison for the rgba downsampler
`timescale 1ns / 100ps

module rbd_halving_check #(
	parameter int unsigned MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [rbd_pkg::PIX_W-1:0]       s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [rbd_pkg::PIX_W-1:0]       m_tdata,
	input  logic                            m_tlast,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [rbd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rbd_pkg::DIM_W-1:0]       cfg_data,
	output int unsigned                     pending,
	output int unsigned                     fail_count
);

	localparam int unsigned UAW = (MAX_WIDTH > 3) ? $clog2(MAX_WIDTH / 2) : 1;

	typedef struct packed {
		logic                                         last;
		logic [rbd_pkg::LANES-1:0][rbd_pkg::CHAN_W-1:0] chan;
	} halved_px_t;

	logic [rbd_pkg::DIM_W-1:0] width_reg;
	logic [rbd_pkg::DIM_W-1:0] height_reg;
	int unsigned               col_pos;
	int unsigned               row_pos;
	logic [rbd_pkg::SUM_W-1:0] left_pix;
	logic [rbd_pkg::SUM_W-1:0] upper_sums [MAX_WIDTH/2];
	halved_px_t                awaited_px [$];
	int unsigned               errors;

	// one source pixel: keep the left of a pair, store upper pair sums,
	// and on a lower pair finish the block
	task automatic predict_pixel(input logic [rbd_pkg::PIX_W-1:0] pix);
		int unsigned               w;
		int unsigned               h;
		int unsigned               col;
		int unsigned               row;
		int unsigned               pair;
		logic [rbd_pkg::SUM_W-1:0] lanes;
		logic [rbd_pkg::SUM_W-1:0] hsum;
		logic [rbd_pkg::SUM_W-1:0] up;
		logic [rbd_pkg::LANE_W:0]  total;
		halved_px_t                px;
		w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
		h = (height_reg == 0) ? 1
			: ((height_reg > rbd_pkg::MAX_HEIGHT) ? rbd_pkg::MAX_HEIGHT : height_reg);
		if (col_pos >= w) col_pos = 0;
		if (row_pos >= h) row_pos = 0;
		col = col_pos;
		row = row_pos;
		pair = col / 2;
		for (int k = 0; k < rbd_pkg::LANES; k++) begin
			lanes[k*rbd_pkg::LANE_W +: rbd_pkg::LANE_W] =
				{1'b0, pix[k*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W]};
		end
		if (col[0] == 1'b0) begin
			left_pix = lanes;
		end else if (pair < w / 2 && pair < MAX_WIDTH / 2) begin
			for (int k = 0; k < rbd_pkg::LANES; k++) begin
				hsum[k*rbd_pkg::LANE_W +: rbd_pkg::LANE_W] =
					left_pix[k*rbd_pkg::LANE_W +: rbd_pkg::LANE_W]
					+ lanes[k*rbd_pkg::LANE_W +: rbd_pkg::LANE_W];
			end
			if (row[0] == 1'b0) begin
				upper_sums[UAW'(pair)] = hsum;
			end else if (row / 2 < h / 2) begin
				up = upper_sums[UAW'(pair)];
				for (int k = 0; k < rbd_pkg::LANES; k++) begin
					total = {1'b0, up[k*rbd_pkg::LANE_W +: rbd_pkg::LANE_W]}
						+ {1'b0, hsum[k*rbd_pkg::LANE_W +: rbd_pkg::LANE_W]};
					px.chan[k] = total[rbd_pkg::LANE_W:2];
				end
				px.last = (row / 2 == h / 2 - 1) && (pair == w / 2 - 1);
				awaited_px = {awaited_px, px};
			end
		end
		col++;
		if (col >= w) begin
			col = 0;
			row++;
			if (row >= h) row = 0;
		end
		col_pos = col;
		row_pos = row;
	endtask

	task automatic check_result(input logic [rbd_pkg::PIX_W-1:0] data, input logic last);
		halved_px_t exp_px;
		bit         bad;
		if (awaited_px.size() == 0) begin
			errors++;
			if (errors <= 10) begin
				$display("%0t: unexpected halved pixel %h last %0b", $realtime, data, last);
			end
			return;
		end
		exp_px = awaited_px.pop_front();
		bad = (exp_px.last != last);
		for (int k = 0; k < rbd_pkg::LANES; k++) begin
			if (exp_px.chan[k] != data[k*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W]) bad = 1'b1;
		end
		if (bad) begin
			errors++;
			if (errors <= 10) begin
				$display("%0t: mismatch, exp %0d %0d %0d %0d/%0b, got %0d %0d %0d %0d/%0b",
					$realtime, exp_px.chan[0], exp_px.chan[1], exp_px.chan[2],
					exp_px.chan[3], exp_px.last, data[7:0], data[15:8], data[23:16],
					data[31:24], last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = rbd_pkg::DIM_W'(rbd_pkg::RESET_DIM);
			height_reg = rbd_pkg::DIM_W'(rbd_pkg::RESET_DIM);
			col_pos = 0;
			row_pos = 0;
			left_pix = '0;
			awaited_px.delete();
			errors = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (m_tvalid && m_tready) check_result(m_tdata, m_tlast);
			// a size write restarts the frame
			if (cfg_valid && cfg_ready) begin
				if (rbd_pkg::cfg_reg_t'(cfg_index) == rbd_pkg::REG_SOURCE_WIDTH) begin
					width_reg = cfg_data;
				end else begin
					height_reg = cfg_data;
				end
				col_pos = 0;
				row_pos = 0;
				left_pix = '0;
			end
			if (s_tvalid && s_tready) predict_pixel(s_tdata);
			pending <= awaited_px.size();
			fail_count <= errors;
		end
	end

endmodule

/* sim/testbench.sv */
// top of the rgba downsampler testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module testbench;

	logic                            clk;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [rbd_pkg::PIX_W-1:0]       s_tdata   = '0;   // red_in, green_in, blue_in, alpha_in
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [rbd_pkg::PIX_W-1:0]       m_tdata;          // red_out, green_out, blue_out, alpha_out
	logic                            m_tlast;          // frame_last
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [rbd_pkg::CFG_INDEX_W-1:0] cfg_index = rbd_pkg::REG_SOURCE_WIDTH;
	logic [rbd_pkg::DIM_W-1:0]       cfg_data  = '0;
	int unsigned                     pending;
	int unsigned                     fail_count;
	// set while a stretch runs with both sides always ready
	bit                              no_gaps   = 1'b0;

	rgba_box_downsample_by_two u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rbd_halving_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// 20 ns period
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// output side stalls about a quarter of the time
	always @(posedge clk) begin
		m_tready <= no_gaps || ($urandom_range(99) >= 26);
	end

	// one source pixel transfer, with random idle cycles ahead of it;
	// tvalid stays high into the next call when no idle cycle is drawn
	task automatic push_pixel(input logic [rbd_pkg::PIX_W-1:0] pix);
		while (!no_gaps && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		do @(posedge clk); while (!s_tready);
	endtask

	// size register writes, width first; valid is held across both transfers
	task automatic write_sizes(input bit wr_w, input logic [rbd_pkg::DIM_W-1:0] w,
		input bit wr_h, input logic [rbd_pkg::DIM_W-1:0] h);
		if (wr_w) begin
			cfg_valid <= 1'b1;
			cfg_index <= rbd_pkg::REG_SOURCE_WIDTH;
			cfg_data <= w;
			do @(posedge clk); while (!cfg_ready);
		end
		if (wr_h) begin
			cfg_valid <= 1'b1;
			cfg_index <= rbd_pkg::REG_SOURCE_HEIGHT;
			cfg_data <= h;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// stop sending, let every expected pixel arrive, then cover the
	// input register and read stage for pixels that give no result
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int unsigned pixels_sent;
		int unsigned cur_w;
		int unsigned cur_h;
		int unsigned eff_w;
		int unsigned eff_h;
		int unsigned frame_px;
		int unsigned n;
		int unsigned pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		pixels_sent = 0;

		// reset sizes are 4096 x 4096: the start of the first row writes pair sums into the line store
		for (int i = 0; i < 200; i++) push_pixel($urandom);
		drain();
		pixels_sent += 200;

		// 2x2 pictures: all channels at full scale, then truncation per channel;
		// the second frame also checks the wrap after the last pixel
		write_sizes(1'b1, rbd_pkg::DIM_W'(2), 1'b1, rbd_pkg::DIM_W'(2));
		repeat (4) push_pixel('1);
		push_pixel({8'd128, 8'd1, 8'd0, 8'd255});
		push_pixel({8'd127, 8'd2, 8'd0, 8'd255});
		push_pixel({8'd0,   8'd3, 8'd0, 8'd255});
		push_pixel({8'd255, 8'd4, 8'd3, 8'd254});
		drain();
		pixels_sent += 8;

		// odd sizes drop the last row and column
		write_sizes(1'b1, rbd_pkg::DIM_W'(3), 1'b1, rbd_pkg::DIM_W'(3));
		repeat (9) push_pixel($urandom);
		drain();
		pixels_sent += 9;

		// zero width or height counts as one, so nothing comes out
		write_sizes(1'b1, rbd_pkg::DIM_W'(0), 1'b1, rbd_pkg::DIM_W'(5));
		repeat (3) push_pixel($urandom);
		drain();
		write_sizes(1'b1, rbd_pkg::DIM_W'(5), 1'b1, rbd_pkg::DIM_W'(0));
		repeat (3) push_pixel($urandom);
		drain();
		pixels_sent += 6;

		// oversized width saturates to the full line store
		write_sizes(1'b1, '1, 1'b1, rbd_pkg::DIM_W'(2));
		for (int i = 0; i < 200; i++) push_pixel($urandom);
		drain();
		pixels_sent += 200;

		// oversized height saturates to 8192 rows; this stretch runs without gaps
		no_gaps = 1'b1;
		write_sizes(1'b1, rbd_pkg::DIM_W'(2), 1'b1, '1);
		for (int i = 0; i < 256; i++) push_pixel($urandom);
		drain();
		pixels_sent += 256;
		no_gaps = 1'b0;
		cur_w = 2;
		cur_h = 16383;

		// random phases: mostly whole small frames, some cut short, and now and
		// then a single register write that restarts the frame mid-way
		while (pixels_sent < 1300) begin
			pick = $urandom_range(9);
			if (pick != 1) begin
				n = $urandom_range(99);
				if (n < 80) cur_w = $urandom_range(12, 1);
				else if (n < 95) cur_w = $urandom_range(80, 13);
				else cur_w = $urandom_range(1) ? 0 : $urandom_range(16383, 8193);
			end
			if (pick != 0) begin
				n = $urandom_range(99);
				if (n < 80) cur_h = $urandom_range(10, 1);
				else if (n < 95) cur_h = $urandom_range(40, 11);
				else cur_h = $urandom_range(1) ? 0 : $urandom_range(16383, 8193);
			end
			write_sizes(pick != 1, rbd_pkg::DIM_W'(cur_w), pick != 0, rbd_pkg::DIM_W'(cur_h));
			eff_w = (cur_w == 0) ? 1
				: ((cur_w > rbd_pkg::MAX_WIDTH_DEFAULT) ? rbd_pkg::MAX_WIDTH_DEFAULT : cur_w);
			eff_h = (cur_h == 0) ? 1
				: ((cur_h > rbd_pkg::MAX_HEIGHT) ? rbd_pkg::MAX_HEIGHT : cur_h);
			frame_px = eff_w * eff_h;
			if ($urandom_range(3) != 0 && frame_px <= 400) begin
				n = frame_px * $urandom_range(3, 1);
			end else begin
				n = $urandom_range((frame_px < 150) ? 2 * frame_px : 300, 1);
			end
			for (int i = 0; i < n; i++) push_pixel($urandom);
			pixels_sent += n;
			drain();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// watchdog, far above the slowest correct run
	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/rbd_pkg.sv
rtl/rbd_line_store.sv
rtl/rgba_box_downsample_by_two.sv
sim/rbd_halving_check.sv
sim/testbench.sv
